FILE: sv/sc2a_pkg.sv
// ----------------------------------------------------------------------------
// sc2a_pkg
// Shared types, codes and the set 1 ASCII table for the scancode decoder.
// ----------------------------------------------------------------------------
package sc2a_pkg;

   localparam int QUEUE_DEPTH_DEF = 256;

   localparam logic [1:0] OP_SCAN      = 2'd0;
   localparam logic [1:0] OP_POP_CHAR  = 2'd1;
   localparam logic [1:0] OP_POP_EVENT = 2'd2;

   localparam logic [6:0] SC_ALT      = 7'h38;
   localparam logic [6:0] SC_CTRL     = 7'h1D;
   localparam logic [6:0] SC_SHIFT    = 7'h2A;
   localparam logic [7:0] CASE_OFFSET = 8'd32;
   localparam int         TABLE_LEN   = 58;

   localparam logic [7:0] ASCII_MAP [TABLE_LEN] = '{
      8'd0,   8'd27,  8'h31,  8'h32,  8'h33,  8'h34,  8'h35,  8'h36,
      8'h37,  8'h38,  8'h39,  8'h30,  8'h2D,  8'h3D,  8'd8,   8'd9,
      8'h71,  8'h77,  8'h65,  8'h72,  8'h74,  8'h79,  8'h75,  8'h69,
      8'h6F,  8'h70,  8'h5B,  8'h5D,  8'd10,  8'd0,   8'h61,  8'h73,
      8'h64,  8'h66,  8'h67,  8'h68,  8'h6A,  8'h6B,  8'h6C,  8'h3B,
      8'd39,  8'h60,  8'd0,   8'd92,  8'h7A,  8'h78,  8'h63,  8'h76,
      8'h62,  8'h6E,  8'h6D,  8'h2C,  8'h2E,  8'h2F,  8'd0,   8'h2A,
      8'd0,   8'h20
   };

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctrl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   // map a 7-bit code to ASCII; letters go upper case while shift is held
   function automatic logic [7:0] ascii_lookup(input logic [6:0] code, input logic shift);
      logic [7:0] c;
      c = (int'(code) < TABLE_LEN) ? ASCII_MAP[code[5:0]] : 8'd0;
      if (shift && c >= 8'h61 && c <= 8'h7A) begin
         c = c - CASE_OFFSET;
      end
      return c;
   endfunction

endpackage

FILE: sv/sc2a_req_if.sv
// ----------------------------------------------------------------------------
// sc2a_req_if
// Request channel: opcode and raw scancode byte.
// ----------------------------------------------------------------------------
interface sc2a_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] scan_byte;

   modport source (output valid, output opcode, output scan_byte, input ready);
   modport sink   (input valid, input opcode, input scan_byte, output ready);
endinterface

FILE: sv/sc2a_rsp_if.sv
// ----------------------------------------------------------------------------
// sc2a_rsp_if
// Response channel: popped entries, modifier state and drop flag.
// ----------------------------------------------------------------------------
interface sc2a_rsp_if;
   logic              valid;
   logic              ready;
   logic        [7:0] popped_char;
   logic signed [7:0] popped_key_event;
   logic              shift_held;
   logic              ctrl_held;
   logic              alt_held;
   logic              entry_dropped;

   modport source (output valid, output popped_char, output popped_key_event,
                   output shift_held, output ctrl_held, output alt_held,
                   output entry_dropped, input ready);
   modport sink   (input valid, input popped_char, input popped_key_event,
                   input shift_held, input ctrl_held, input alt_held,
                   input entry_dropped, output ready);
endinterface

FILE: sv/sc2a_fifo.sv
// ----------------------------------------------------------------------------
// sc2a_fifo
// Byte queue in a synchronous memory; one slot kept free to tell full
// from empty. Pushes to a full queue and pops from an empty one are ignored.
// ----------------------------------------------------------------------------
module sc2a_fifo #(
   parameter int DEPTH = sc2a_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sc2a_pkg::fifo_ctrl_type ctrl,
   input  logic [7:0]             push_data,
   output sc2a_pkg::fifo_stat_type stat,
   output logic [7:0]             rd_data
);
   import sc2a_pkg::*;

   localparam int            PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

   logic [7:0]    mem [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [7:0]    rd_data_ff;
   logic          do_push, do_pop;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      return (p == LAST) ? '0 : PW'(p + 1'b1);
   endfunction

   always_comb begin
      stat.full  = (bump(wr_ptr_ff) == rd_ptr_ff);
      stat.empty = (wr_ptr_ff == rd_ptr_ff);
      do_push    = ctrl.push && !stat.full;
      do_pop     = ctrl.pop && !stat.empty;
      wr_ptr_in  = do_push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in  = do_pop ? bump(rd_ptr_ff) : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // a pop only reads slots written by an earlier item, so no bypass needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
      if (do_pop) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/scancode_to_ascii_with_key_queues.sv
// ----------------------------------------------------------------------------
// scancode_to_ascii_with_key_queues
// Set 1 scancode decoder with a character queue and a key event queue.
// ----------------------------------------------------------------------------
// A request beat is accepted in the idle state; its queue memory read follows
// in the read state, which takes no new request, and then the response registers.
// A new request is taken while the previous response waits, if it is taken
// in that cycle. Reset (synchronous) clears modifiers and queue pointers;
// queue memory contents stay undefined and need no clearing.
module scancode_to_ascii_with_key_queues #(
   parameter int QUEUE_DEPTH = sc2a_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   sc2a_req_if.sink          req_bus,
   sc2a_rsp_if.source        rsp_bus
);
   import sc2a_pkg::*;

   state_type     state_ff, state_in;
   logic          shift_ff, shift_in;
   logic          ctrl_ff, ctrl_in;
   logic          alt_ff, alt_in;
   logic          pend_char_ff, pend_char_in;
   logic          pend_event_ff, pend_event_in;
   logic          dropped_ff, dropped_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_char_ff, rsp_char_in;
   logic [7:0]    rsp_event_ff, rsp_event_in;
   logic          rsp_drop_ff, rsp_drop_in;

   logic          accept;
   logic [6:0]    code;
   logic          release_bit;
   logic [7:0]    ch;
   fifo_ctrl_type char_ctrl, event_ctrl;
   fifo_stat_type char_stat, event_stat;
   logic [7:0]    event_data;
   logic [7:0]    char_rd, event_rd;

   always_comb begin
      req_bus.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
      accept        = req_bus.valid && req_bus.ready;
      code          = req_bus.scan_byte[6:0];
      release_bit   = req_bus.scan_byte[7];

      state_in      = state_ff;
      shift_in      = shift_ff;
      ctrl_in       = ctrl_ff;
      alt_in        = alt_ff;
      pend_char_in  = pend_char_ff;
      pend_event_in = pend_event_ff;
      dropped_in    = dropped_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_char_in   = rsp_char_ff;
      rsp_event_in  = rsp_event_ff;
      rsp_drop_in   = rsp_drop_ff;
      char_ctrl     = '0;
      event_ctrl    = '0;

      if (req_bus.opcode == OP_SCAN) begin
         if (code == SC_ALT) alt_in = !release_bit;
         if (code == SC_CTRL) ctrl_in = !release_bit;
         if (code == SC_SHIFT) shift_in = !release_bit;
      end
      ch         = ascii_lookup(code, shift_in);
      event_data = release_bit ? 8'(8'd0 - ch) : ch;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in      = S_READ;
               pend_char_in  = 1'b0;
               pend_event_in = 1'b0;
               dropped_in    = 1'b0;
               case (req_bus.opcode)
                  OP_SCAN: begin
                     char_ctrl.push  = (ch != 8'd0) && !release_bit;
                     event_ctrl.push = (ch != 8'd0);
                     dropped_in = (char_ctrl.push && char_stat.full) ||
                                  (event_ctrl.push && event_stat.full);
                  end
                  OP_POP_CHAR: begin
                     char_ctrl.pop = 1'b1;
                     pend_char_in  = !char_stat.empty;
                  end
                  OP_POP_EVENT: begin
                     event_ctrl.pop = 1'b1;
                     pend_event_in  = !event_stat.empty;
                  end
                  default: begin
                  end
               endcase
            end else begin
               shift_in = shift_ff;
               ctrl_in  = ctrl_ff;
               alt_in   = alt_ff;
            end
         end
         S_READ: begin
            // output slot was freed when this item was taken
            shift_in     = shift_ff;
            ctrl_in      = ctrl_ff;
            alt_in       = alt_ff;
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            rsp_char_in  = pend_char_ff ? char_rd : 8'd0;
            rsp_event_in = pend_event_ff ? event_rd : 8'd0;
            rsp_drop_in  = dropped_ff;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         shift_ff     <= 1'b0;
         ctrl_ff      <= 1'b0;
         alt_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         shift_ff     <= shift_in;
         ctrl_ff      <= ctrl_in;
         alt_ff       <= alt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_char_ff  <= pend_char_in;
      pend_event_ff <= pend_event_in;
      dropped_ff    <= dropped_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_event_ff  <= rsp_event_in;
      rsp_drop_ff   <= rsp_drop_in;
   end

   sc2a_fifo #(.DEPTH(QUEUE_DEPTH)) u_char_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (char_ctrl),
      .push_data (ch),
      .stat      (char_stat),
      .rd_data   (char_rd)
   );

   sc2a_fifo #(.DEPTH(QUEUE_DEPTH)) u_event_fifo (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (event_ctrl),
      .push_data (event_data),
      .stat      (event_stat),
      .rd_data   (event_rd)
   );

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.popped_char      = rsp_char_ff;
   assign rsp_bus.popped_key_event = signed'(rsp_event_ff);
   assign rsp_bus.shift_held       = shift_ff;
   assign rsp_bus.ctrl_held        = ctrl_ff;
   assign rsp_bus.alt_held         = alt_ff;
   assign rsp_bus.entry_dropped    = rsp_drop_ff;

   a_accept_to_read: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_READ)
      else $error("accepted beat did not start a queue read");

   a_read_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |=> rsp_valid_ff)
      else $error("queue read did not produce a response beat");

   a_one_pop_field: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_char_ff != 8'd0 |-> rsp_event_ff == 8'd0)
      else $error("both popped fields nonzero in one beat");

   a_no_accept_in_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> !req_bus.ready)
      else $error("request taken during queue read");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the set 1 scancode decoder against a cycle-free model of its
// modifier flags and its two queues. Every request beat updates the model,
// and every response beat is checked field by field against the oldest
// prediction. Covers directed corner codes, both queues run past capacity
// and wrapped, and random key traffic under several stall patterns.
// ----------------------------------------------------------------------------
module tb;
   import sc2a_pkg::*;

   localparam int         QD          = QUEUE_DEPTH_DEF;
   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         Q_CHAR      = 0;
   localparam int         Q_EVENT     = 1;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         HOLD_CYCLES = 300;
   localparam int         MAX_REPORTS = 10;

   typedef struct packed {
      logic [7:0] ch;
      logic [7:0] ev;
      logic       shift_on;
      logic       ctrl_on;
      logic       alt_on;
      logic       dropped;
   } decode_rsp_type;

   logic clock = 1'b0;
   logic reset;

   sc2a_req_if req_bus ();
   sc2a_rsp_if rsp_bus ();

   scancode_to_ascii_with_key_queues #(
      .QUEUE_DEPTH(QD)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   // decoder model state
   logic           shift_now = 1'b0;
   logic           ctrl_now  = 1'b0;
   logic           alt_now   = 1'b0;
   logic [7:0]     queue_mem [2][QD];
   int             queue_wr [2] = '{0, 0};
   int             queue_rd [2] = '{0, 0};
   decode_rsp_type expected_rsp [$];

   int   tx_idle_pct = 0;
   int   rx_idle_pct = 0;
   logic hold_active = 1'b0;
   event start_hold;

   int beats_sent  = 0;
   int rsp_checked = 0;
   int drops_seen  = 0;
   int mismatches  = 0;
   int cycle_count = 0;

   function automatic int queue_level(input int q);
      return (queue_wr[q] - queue_rd[q] + QD) % QD;
   endfunction

   // returns 1 when the queue is full and the entry is refused
   function automatic logic queue_push(input int q, input logic [7:0] v);
      int nx;
      nx = (queue_wr[q] + 1) % QD;
      if (nx == queue_rd[q]) return 1'b1;
      queue_mem[q][queue_wr[q]] = v;
      queue_wr[q] = nx;
      return 1'b0;
   endfunction

   function automatic logic [7:0] queue_pop(input int q);
      logic [7:0] v;
      if (queue_wr[q] == queue_rd[q]) return 8'd0;
      v = queue_mem[q][queue_rd[q]];
      queue_rd[q] = (queue_rd[q] + 1) % QD;
      return v;
   endfunction

   function automatic logic [7:0] char_of(input logic [6:0] code);
      logic [7:0] c;
      c = 8'd0;
      if (int'(code) < TABLE_LEN) c = ASCII_MAP[code[5:0]];
      if (shift_now && c >= 8'h61 && c <= 8'h7A) c = c - CASE_OFFSET;
      return c;
   endfunction

   task automatic predict_rsp(input logic [1:0] op, input logic [7:0] sc);
      decode_rsp_type r;
      logic [7:0]     c;
      logic           drop_ch;
      logic           drop_ev;
      r = '0;
      case (op)
         OP_SCAN: begin
            // make sets the modifier, break clears it; lookup sees the new state
            if (sc[6:0] == SC_ALT)   alt_now   = ~sc[7];
            if (sc[6:0] == SC_CTRL)  ctrl_now  = ~sc[7];
            if (sc[6:0] == SC_SHIFT) shift_now = ~sc[7];
            c = char_of(sc[6:0]);
            if (c != 8'd0) begin
               if (!sc[7]) begin
                  drop_ch = queue_push(Q_CHAR, c);
                  drop_ev = queue_push(Q_EVENT, c);
                  r.dropped = drop_ch | drop_ev;
               end else begin
                  r.dropped = queue_push(Q_EVENT, 8'd0 - c);
               end
            end
         end
         OP_POP_CHAR: begin
            r.ch = queue_pop(Q_CHAR);
         end
         OP_POP_EVENT: begin
            r.ev = queue_pop(Q_EVENT);
         end
         default: begin
         end
      endcase
      r.shift_on = shift_now;
      r.ctrl_on  = ctrl_now;
      r.alt_on   = alt_now;
      expected_rsp.push_back(r);
   endtask

   task automatic send_beat(input logic [1:0] op, input logic [7:0] sc);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.opcode    <= op;
      req_bus.scan_byte <= sc;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_rsp(op, sc);
      beats_sent++;
   endtask

   task automatic wait_for_responses();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_rsp.size() != 0);
   endtask

   task automatic report_error(input string what, input logic [7:0] want,
                               input logic [7:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("[%0t] mismatch on %s: expected %h, got %h (response %0d)",
                  $realtime, what, want, got, rsp_checked);
   endtask

   task automatic check_rsp();
      decode_rsp_type want;
      if (expected_rsp.size() == 0) begin
         report_error("unexpected response beat", 8'd0, 8'd0);
         return;
      end
      want = expected_rsp.pop_front();
      if (rsp_bus.popped_char !== want.ch)
         report_error("popped_char", want.ch, rsp_bus.popped_char);
      if (rsp_bus.popped_key_event !== want.ev)
         report_error("popped_key_event", want.ev, rsp_bus.popped_key_event);
      if (rsp_bus.shift_held !== want.shift_on)
         report_error("shift_held", 8'(want.shift_on), 8'(rsp_bus.shift_held));
      if (rsp_bus.ctrl_held !== want.ctrl_on)
         report_error("ctrl_held", 8'(want.ctrl_on), 8'(rsp_bus.ctrl_held));
      if (rsp_bus.alt_held !== want.alt_on)
         report_error("alt_held", 8'(want.alt_on), 8'(rsp_bus.alt_held));
      if (rsp_bus.entry_dropped !== want.dropped)
         report_error("entry_dropped", 8'(want.dropped), 8'(rsp_bus.entry_dropped));
      if (want.dropped) drops_seen++;
      rsp_checked++;
   endtask

   // response side: check each beat, then pick next cycle's ready
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) check_rsp();
      rsp_bus.ready <= !hold_active && ($urandom_range(99) >= rx_idle_pct);
   end

   // long receiver stall, counted here so the sender keeps pushing meanwhile
   always begin
      @(start_hold);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses still due",
                  cycle_count, expected_rsp.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic logic [6:0] pick_char_code();
      int c;
      do c = $urandom_range(1, TABLE_LEN - 1); while (ASCII_MAP[c[5:0]] == 8'd0);
      return 7'(c);
   endfunction

   // mostly well-formed key presses and releases, some modifiers, some noise
   function automatic logic [7:0] pick_scan();
      int         r;
      logic [6:0] m;
      r = $urandom_range(99);
      if (r < 55) return {1'b0, pick_char_code()};
      if (r < 80) return {1'b1, pick_char_code()};
      if (r < 92) begin
         r = $urandom_range(2);
         m = (r == 0) ? SC_ALT : (r == 1) ? SC_CTRL : SC_SHIFT;
         return {1'($urandom_range(1)), m};
      end
      return 8'($urandom);
   endfunction

   task automatic test_directed();
      send_beat(OP_POP_CHAR, 8'hFF);            // empty queues give zero
      send_beat(OP_POP_EVENT, 8'h00);
      send_beat(OP_UNUSED, 8'hFF);
      send_beat(OP_SCAN, 8'h1E);                // 'a'
      send_beat(OP_SCAN, {1'b0, SC_SHIFT});
      send_beat(OP_SCAN, 8'h10);                // 'Q' while shifted
      send_beat(OP_SCAN, 8'h90);                // release of 'Q'
      send_beat(OP_SCAN, {1'b1, SC_SHIFT});
      send_beat(OP_SCAN, {1'b0, SC_CTRL});
      send_beat(OP_SCAN, {1'b0, SC_ALT});
      send_beat(OP_SCAN, 8'h9E);                // release of 'a'
      send_beat(OP_SCAN, {1'b1, SC_CTRL});
      send_beat(OP_SCAN, {1'b1, SC_ALT});
      send_beat(OP_SCAN, 8'h39);                // space, last table slot
      send_beat(OP_SCAN, 8'h7F);                // past the table
      send_beat(OP_SCAN, 8'h00);                // zero table slot
      send_beat(OP_SCAN, 8'hFF);
      send_beat(OP_SCAN, 8'h80);
      repeat (3) send_beat(OP_POP_CHAR, 8'h55);
      repeat (5) send_beat(OP_POP_EVENT, 8'hAA);
   endtask

   task automatic test_queue_full();
      while (queue_level(Q_CHAR) != 0) send_beat(OP_POP_CHAR, 8'($urandom));
      while (queue_level(Q_EVENT) != 0) send_beat(OP_POP_EVENT, 8'($urandom));
      // both queues reach capacity together, then refuse
      while (queue_level(Q_CHAR) < QD - 1) send_beat(OP_SCAN, {1'b0, pick_char_code()});
      repeat (2) send_beat(OP_SCAN, {1'b0, pick_char_code()});
      // full char queue must not stop the event push; event pointer wraps
      repeat (2) send_beat(OP_POP_EVENT, 8'h00);
      send_beat(OP_SCAN, {1'b0, pick_char_code()});
      repeat (2) send_beat(OP_SCAN, {1'b1, pick_char_code()});
      // and the other way round; char pointer wraps
      repeat (3) send_beat(OP_POP_CHAR, 8'h00);
      send_beat(OP_SCAN, {1'b0, pick_char_code()});
   endtask

   task automatic test_random(input int n, input int scan_pct);
      int r;
      repeat (n) begin
         r = $urandom_range(99);
         if (r < scan_pct)
            send_beat(OP_SCAN, pick_scan());
         else if (r < 97)
            send_beat($urandom_range(1) ? OP_POP_CHAR : OP_POP_EVENT, 8'($urandom));
         else
            send_beat(OP_UNUSED, 8'($urandom));
      end
   endtask

   task automatic test_backpressure();
      int saved_idle;
      saved_idle  = tx_idle_pct;
      tx_idle_pct = 0;
      -> start_hold;
      test_random(24, 60);
      tx_idle_pct = saved_idle;
   endtask

   task automatic test_sender_pause();
      test_random(20, 55);
      wait_for_responses();
      test_random(20, 55);
   endtask

   initial begin
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.opcode    <= OP_SCAN;
      req_bus.scan_byte <= 8'h00;
      tx_idle_pct = 36;
      rx_idle_pct = 70;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_queue_full();
      // pop-heavy so the queues come back down from full
      test_random(100, 35);

      tx_idle_pct = 70;
      rx_idle_pct = 36;
      test_backpressure();
      test_random(80, 55);
      test_sender_pause();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      test_random(110, 60);

      wait_for_responses();
      repeat (10) @(posedge clock);

      $display("Sent %0d request beats, checked %0d responses, %0d with a refused push.",
               beats_sent, rsp_checked, drops_seen);
      $display("Both queues were run past capacity and wrapped; %0d mismatches.",
               mismatches);
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/sc2a_pkg.sv
sv/sc2a_req_if.sv
sv/sc2a_rsp_if.sv
sv/sc2a_fifo.sv
sv/scancode_to_ascii_with_key_queues.sv
bench/tb.sv
